// ===== rtl/core/rig_pkg.sv =====
// Shared constants, types and state encoding for the radical inverse generator.
`default_nettype none

package rig_pkg;

   localparam int IDX_BITS          = 32;
   localparam int RADIX_BITS        = 8;
   localparam int FIX_BITS          = 40;
   localparam int W_BITS            = FIX_BITS + 1;
   localparam int PROD_BITS         = W_BITS + RADIX_BITS;
   localparam int OUT_FRAC_BITS_DEF = 24;
   localparam int CNT_BITS          = $clog2(W_BITS);
   localparam int RADIX_MIN         = 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_IDX,
      ST_IDX_SAVE,
      ST_DIV_W,
      ST_W_SAVE,
      ST_MUL,
      ST_ADD,
      ST_FINISH
   } rig_state_type;

   typedef struct packed {
      logic load;
      logic div_load_idx;
      logic div_load_w;
      logic div_step;
      logic save_idx;
      logic save_w;
      logic mul;
      logic add;
      logic out_load;
   } rig_cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic radix_small;
   } rig_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/rig_req_if.sv =====
// Request channel: sample index and radix words.
`default_nettype none

interface rig_req_if;
   logic                            valid;
   logic                            ready;
   logic [rig_pkg::IDX_BITS-1:0]    sample_index;
   logic [rig_pkg::RADIX_BITS-1:0]  radix;

   modport source (output valid, output sample_index, output radix, input ready);
   modport sink   (input valid, input sample_index, input radix, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rig_rsp_if.sv =====
// Response channel: radical inverse fraction words.
`default_nettype none

interface rig_rsp_if #(
   parameter int OUT_FRAC_BITS = rig_pkg::OUT_FRAC_BITS_DEF
);
   logic                     valid;
   logic                     ready;
   logic [OUT_FRAC_BITS-1:0] fraction;

   modport source (output valid, output fraction, input ready);
   modport sink   (input valid, input fraction, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rig_dp.sv =====
// Datapath: index, weight and accumulator registers with a shared serial divider.
`default_nettype none

module rig_dp #(
   parameter int OUT_FRAC_BITS = rig_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire rig_pkg::rig_cmd_type             cmd,
   output rig_pkg::rig_status_type               status,
   input  wire logic [rig_pkg::IDX_BITS-1:0]     sample_index,
   input  wire logic [rig_pkg::RADIX_BITS-1:0]   radix,
   output logic      [OUT_FRAC_BITS-1:0]         fraction
);
   import rig_pkg::*;

   localparam logic [W_BITS-1:0] W_ONE = W_BITS'(1) << FIX_BITS;

   logic [IDX_BITS-1:0]      idx_ff;
   logic [RADIX_BITS-1:0]    radix_ff;
   logic [W_BITS-1:0]        w_ff;
   logic [FIX_BITS-1:0]      acc_ff;
   logic [RADIX_BITS-1:0]    digit_ff;
   logic [W_BITS-1:0]        quo_ff;
   logic [W_BITS-1:0]        quo_in;
   logic [RADIX_BITS-1:0]    rem_ff;
   logic [RADIX_BITS-1:0]    rem_in;
   logic [FIX_BITS-1:0]      prod_ff;
   logic [FIX_BITS-1:0]      prod_in;
   logic [OUT_FRAC_BITS-1:0] fraction_ff;
   logic [RADIX_BITS:0]      trial;
   logic [RADIX_BITS:0]      diff;
   logic [PROD_BITS-1:0]     prod_full;

   // One restoring step: bring down the next dividend bit and try the radix.
   always_comb begin
      trial = {rem_ff, quo_ff[W_BITS-1]};
      diff  = trial - {1'b0, radix_ff};
      if (trial >= {1'b0, radix_ff}) begin
         rem_in = diff[RADIX_BITS-1:0];
         quo_in = {quo_ff[W_BITS-2:0], 1'b1};
      end else begin
         rem_in = trial[RADIX_BITS-1:0];
         quo_in = {quo_ff[W_BITS-2:0], 1'b0};
      end
   end

   assign prod_full = PROD_BITS'(w_ff) * PROD_BITS'(digit_ff);
   assign prod_in   = prod_full[FIX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff   <= sample_index;
         radix_ff <= radix;
         w_ff     <= W_ONE;
         acc_ff   <= '0;
      end
      if (cmd.save_idx) begin
         idx_ff   <= quo_ff[IDX_BITS-1:0];
         digit_ff <= rem_ff;
      end
      // The index is placed at the top so that 32 steps leave its quotient at the bottom.
      if (cmd.div_load_idx) begin
         quo_ff <= {idx_ff, {(W_BITS-IDX_BITS){1'b0}}};
         rem_ff <= '0;
      end else if (cmd.div_load_w) begin
         quo_ff <= w_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.save_w) begin
         w_ff <= quo_ff;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.add) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.out_load) begin
         fraction_ff <= acc_ff[FIX_BITS-1 -: OUT_FRAC_BITS];
      end
   end

   assign status.idx_zero    = (idx_ff == '0);
   assign status.radix_small = (radix_ff < RADIX_BITS'(RADIX_MIN));
   assign fraction           = fraction_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rig_ctrl.sv =====
// Controller: sequences digit extraction, weight division and accumulation.
`default_nettype none

module rig_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire rig_pkg::rig_status_type  status,
   output rig_pkg::rig_cmd_type          cmd
);
   import rig_pkg::*;

   localparam logic [CNT_BITS-1:0] IDX_LAST = CNT_BITS'(IDX_BITS - 1);
   localparam logic [CNT_BITS-1:0] W_LAST   = CNT_BITS'(W_BITS - 1);

   rig_state_type       state_ff;
   rig_state_type       state_in;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [CNT_BITS-1:0] cnt_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                finished;

   assign finished = status.idx_zero || status.radix_small;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = finished ? ST_FINISH : ST_DIV_IDX;
         end
         ST_DIV_IDX: begin
            if (cnt_ff == IDX_LAST) state_in = ST_IDX_SAVE;
         end
         ST_IDX_SAVE: begin
            state_in = ST_DIV_W;
         end
         ST_DIV_W: begin
            if (cnt_ff == W_LAST) state_in = ST_W_SAVE;
         end
         ST_W_SAVE: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            cmd.div_load_idx = !finished;
         end
         ST_DIV_IDX: begin
            cmd.div_step = 1'b1;
         end
         ST_IDX_SAVE: begin
            cmd.save_idx   = 1'b1;
            cmd.div_load_w = 1'b1;
         end
         ST_DIV_W: begin
            cmd.div_step = 1'b1;
         end
         ST_W_SAVE: begin
            cmd.save_w = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.div_load_idx || cmd.div_load_w) begin
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/radical_inverse_generator.sv =====
// Top level of the Halton radical inverse generator.
//
//   channel   dir   word contents
//   req_ch    in    sample_index[31:0], radix[7:0]
//   rsp_ch    out   fraction[OUT_FRAC_BITS-1:0]
//
// The work per word grows with D, the number of base-radix digits of
// the index (zero for index 0 or radix below two). Each digit runs the
// shared one-bit-per-cycle divider twice: 32 steps for the index and 41 steps
// for the weight.
// Reset is synchronous and clears the controller and the response valid.
// A new request is taken once the previous one is finished, even while its
// response still waits in the output register for rsp_ch.ready.
`default_nettype none

module radical_inverse_generator #(
   parameter int OUT_FRAC_BITS = rig_pkg::OUT_FRAC_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rig_req_if.sink    req_ch,
   rig_rsp_if.source  rsp_ch
);
   import rig_pkg::*;

   rig_cmd_type    cmd;
   rig_status_type status;

   rig_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rig_dp #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .sample_index (req_ch.sample_index),
      .radix        (req_ch.radix),
      .fraction     (rsp_ch.fraction)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while a word was in progress");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result overwrote an untaken response");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.mul, cmd.add, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== bench/tb_radical_inverse_generator.sv =====
// Self-checking testbench for the radical inverse generator: directed table plus random words.
module tb_radical_inverse_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import rig_pkg::*;

   localparam int OUT_BITS     = OUT_FRAC_BITS_DEF;
   localparam int PHASE_WORDS  = 147;
   localparam int HOLD_CYCLES  = 8000;
   localparam int DRAIN_CYCLES = 2600;
   localparam int LIMIT_CYCLES = 8_000_000;
   localparam int ROW_COUNT    = 23;

   typedef struct {
      logic [IDX_BITS-1:0]   index;
      logic [RADIX_BITS-1:0] radix;
      bit                    typed;
      logic [OUT_BITS-1:0]   fraction;
   } stim_row_type;

   // Rows with typed set carry a fraction that is obvious by hand; the rest use the predictor.
   stim_row_type directed_rows [0:ROW_COUNT-1] = '{
      '{32'h0000_0000, 8'd2,   1'b1, 24'h000000},
      '{32'h0000_0000, 8'd255, 1'b1, 24'h000000},
      '{32'hFFFF_FFFF, 8'd0,   1'b1, 24'h000000},
      '{32'hFFFF_FFFF, 8'd1,   1'b1, 24'h000000},
      '{32'h0000_3039, 8'd1,   1'b1, 24'h000000},
      '{32'h0000_0001, 8'd2,   1'b1, 24'h800000},
      '{32'h0000_0002, 8'd2,   1'b1, 24'h400000},
      '{32'hFFFF_FFFF, 8'd2,   1'b1, 24'hFFFFFF},
      '{32'h8000_0000, 8'd2,   1'b1, 24'h000000},
      '{32'h0000_0003, 8'd4,   1'b1, 24'hC00000},
      '{32'h0000_0001, 8'd128, 1'b1, 24'h020000},
      '{32'hFFFF_FFFF, 8'd16,  1'b1, 24'hFFFFFF},
      '{32'h0000_0001, 8'd255, 1'b0, 24'h000000},
      '{32'hFFFF_FFFF, 8'd255, 1'b0, 24'h000000},
      '{32'hFFFF_FFFF, 8'd3,   1'b0, 24'h000000},
      '{32'h5555_5555, 8'd2,   1'b0, 24'h000000},
      '{32'hAAAA_AAAA, 8'd254, 1'b0, 24'h000000},
      '{32'h0000_0007, 8'd7,   1'b0, 24'h000000},
      '{32'h0000_0006, 8'd7,   1'b0, 24'h000000},
      '{32'h1234_5678, 8'd13,  1'b0, 24'h000000},
      '{32'hFFFF_FFFE, 8'd5,   1'b0, 24'h000000},
      '{32'h0000_FFFF, 8'd251, 1'b0, 24'h000000},
      '{32'hDEAD_BEEF, 8'd3,   1'b0, 24'h000000}
   };

   logic clock;
   logic reset;

   rig_req_if                            req_ch ();
   rig_rsp_if #(.OUT_FRAC_BITS(OUT_BITS)) rsp_ch ();

   radical_inverse_generator #(.OUT_FRAC_BITS(OUT_BITS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [OUT_BITS-1:0] expected_fractions [$];
   logic [OUT_BITS-1:0] front_fraction;
   int                  mismatch_count;
   int                  accepted_words;
   int                  cycle_count;
   int                  send_idle;
   int                  recv_idle;
   logic                hold_off;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirrors the index digits about the radix point with a 1.40 weight.
   function automatic logic [OUT_BITS-1:0] halton_fraction(logic [IDX_BITS-1:0] index,
                                                           logic [RADIX_BITS-1:0] radix);
      logic [FIX_BITS:0]     weight;
      logic [63:0]           accum;
      logic [IDX_BITS-1:0]   rest;
      logic [IDX_BITS-1:0]   digit;
      weight = '0;
      weight[FIX_BITS] = 1'b1;
      accum = '0;
      rest = index;
      if (radix < RADIX_MIN) return '0;
      while (rest != 0) begin
         digit  = rest % IDX_BITS'(radix);
         weight = weight / (FIX_BITS+1)'(radix);
         accum  = accum + 64'(weight) * 64'(digit);
         rest   = rest / IDX_BITS'(radix);
      end
      return OUT_BITS'(accum >> (FIX_BITS - OUT_BITS));
   endfunction

   task automatic report_mismatch(string what, logic [OUT_BITS-1:0] want,
                                  logic [OUT_BITS-1:0] got);
      $display("MISMATCH at cycle %0d, %s: expected %h, got %h", cycle_count, what, want, got);
      mismatch_count++;
   endtask

   // Offers one word after a random gap and returns at the edge that accepts it.
   task automatic send_word(logic [IDX_BITS-1:0] index, logic [RADIX_BITS-1:0] radix,
                            bit typed, logic [OUT_BITS-1:0] fraction);
      while ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.sample_index <= index;
      req_ch.radix        <= radix;
      do @(posedge clock); while (!req_ch.ready);
      expected_fractions.push_back(typed ? fraction : halton_fraction(index, radix));
      accepted_words++;
   endtask

   // Small radices are kept rare so that long digit chains stay occasional.
   task automatic send_random_words(int count);
      logic [IDX_BITS-1:0]   index;
      logic [RADIX_BITS-1:0] radix;
      int                    pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) radix = RADIX_BITS'($urandom_range(0, 1));
         else if (pick < 20) radix = RADIX_BITS'($urandom_range(2, 7));
         else if (pick < 55) radix = RADIX_BITS'($urandom_range(8, 31));
         else if (pick < 90) radix = RADIX_BITS'($urandom_range(32, 255));
         else radix = RADIX_BITS'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 55) index = $urandom;
         else if (pick < 85) index = IDX_BITS'($urandom_range(0, 1000));
         else index = (IDX_BITS'(1) << $urandom_range(0, 31)) - IDX_BITS'($urandom_range(0, 1));
         send_word(index, radix, 1'b0, '0);
      end
   endtask

   task automatic wait_for_drain();
      while (expected_fractions.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_fractions.size() == 0) begin
               report_mismatch("unexpected word", '0, rsp_ch.fraction);
            end else begin
               front_fraction = expected_fractions.pop_front();
               if (rsp_ch.fraction !== front_fraction)
                  report_mismatch("fraction", front_fraction, rsp_ch.fraction);
            end
         end
         rsp_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Long receiver stall in the middle of the second phase, so the block backs up.
   initial begin
      hold_off = 1'b0;
      wait (accepted_words == ROW_COUNT + PHASE_WORDS + 40);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count <= LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      mismatch_count      = 0;
      accepted_words      = 0;
      send_idle           = 38;
      recv_idle           = 68;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.sample_index = '0;
      req_ch.radix        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROW_COUNT; r++)
         send_word(directed_rows[r].index, directed_rows[r].radix,
                   directed_rows[r].typed, directed_rows[r].fraction);
      send_random_words(PHASE_WORDS);
      req_ch.valid <= 1'b0;
      wait_for_drain();

      send_idle = 68;
      recv_idle = 38;
      send_random_words(PHASE_WORDS);
      req_ch.valid <= 1'b0;
      wait_for_drain();

      send_idle = 0;
      recv_idle = 0;
      send_random_words(PHASE_WORDS - 1);
      req_ch.valid <= 1'b0;
      wait_for_drain();

      // Any late or extra word would show up during this tail.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_fractions.size() != 0)
         report_mismatch("word never arrived", expected_fractions[0], '0);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
